// ----- rtl/core/shad_pkg.sv -----
// shad_pkg: types, round constants and round function for the double sha-256 nonce checker
// used by shad_comp and header_nonce_double_sha256_check_top; no dependencies
package shad_pkg;

   typedef logic [7:0][31:0]  hash_type;
   typedef logic [15:0][31:0] block_type;

   // header tail words and nonce that travel with each try
   typedef struct packed {
      logic [31:0] w16;
      logic [31:0] w17;
      logic [31:0] w18;
      logic [31:0] nonce;
   } tag_type;

   typedef struct packed {
      logic        valid;
      hash_type    v;
      hash_type    h0;
      block_type   w;
      tag_type     tag;
   } stage_type;

   typedef struct packed {
      logic        valid;
      hash_type    digest;
      tag_type     tag;
   } digest_type;

   localparam int HeaderWords = 19;
   localparam int BitsWord    = 18;
   localparam int Rounds      = 64;

   localparam logic [31:0] PAD_ONE      = 32'h8000_0000;
   localparam logic [31:0] LEN_HEADER   = 32'h0000_0280;
   localparam logic [31:0] LEN_DIGEST   = 32'h0000_0100;

   localparam hash_type START_H = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam logic [31:0] ROUND_K [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic stage_type sha_round(input stage_type s, input logic [31:0] k);
      stage_type   r;
      logic [31:0] t1;
      logic [31:0] t2;
      logic [31:0] wn;
      r  = s;
      t1 = s.v[7] + (rotr(s.v[4], 6) ^ rotr(s.v[4], 11) ^ rotr(s.v[4], 25))
         + ((s.v[4] & s.v[5]) ^ (~s.v[4] & s.v[6])) + k + s.w[0];
      t2 = (rotr(s.v[0], 2) ^ rotr(s.v[0], 13) ^ rotr(s.v[0], 22))
         + ((s.v[0] & s.v[1]) ^ (s.v[0] & s.v[2]) ^ (s.v[1] & s.v[2]));
      wn = s.w[0] + (rotr(s.w[1], 7) ^ rotr(s.w[1], 18) ^ (s.w[1] >> 3)) + s.w[9]
         + (rotr(s.w[14], 17) ^ rotr(s.w[14], 19) ^ (s.w[14] >> 10));
      r.v[7] = s.v[6];
      r.v[6] = s.v[5];
      r.v[5] = s.v[4];
      r.v[4] = s.v[3] + t1;
      r.v[3] = s.v[2];
      r.v[2] = s.v[1];
      r.v[1] = s.v[0];
      r.v[0] = t1 + t2;
      for (int i = 0; i < 15; i++) begin
         r.w[i] = s.w[i + 1];
      end
      r.w[15] = wn;
      return r;
   endfunction

endpackage

// ----- rtl/core/header_nonce_double_sha256_check_top.sv -----
// header nonce checker: stores a 76-byte header prefix, double sha-256 hashes it with each
// nonce and compares the byte-reversed digest with the compact-bits target.
// one beat per cycle while the output is not stalled; three 64-round compressions of one round per
// stage, each with a final add stage, then a reverse/target stage and a compare stage.
// header words 16 to 18 are captured with each try, so later loads never touch tries in flight.
// depends on shad_pkg and shad_comp
module header_nonce_double_sha256_check_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [71:0]  req_tdata,   // word_index[4:0], word_value[36:5], nonce[68:37], zeros
   input  logic         req_tuser,   // mode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // zero_digits[6:0], nonce_echo[38:7], hash_top[102:39], zero
   output logic         rsp_tuser    // found
);
   import shad_pkg::*;

   typedef struct packed {
      logic         valid;
      logic [255:0] rev;
      logic [255:0] target;
      logic [31:0]  nonce;
   } cmp_type;

   typedef struct packed {
      logic        valid;
      logic        found;
      logic [6:0]  zeros;
      logic [31:0] nonce;
      logic [63:0] top;
   } res_type;

   logic [31:0] hdr_ff [HeaderWords];
   logic        en;
   logic        accept;
   logic [4:0]  word_index;
   logic [31:0] word_value;
   logic [31:0] nonce;
   tag_type     tag1;
   block_type   blk1;
   block_type   blk2;
   block_type   blk3;
   digest_type  d1;
   digest_type  d2;
   digest_type  d3;
   logic [255:0] dig;
   logic [255:0] rev;
   logic [7:0]   expo;
   logic [4:0]   shift;
   logic [255:0] target;
   cmp_type     cmp_ff;
   cmp_type     cmp_in;
   res_type     res_ff;
   res_type     res_in;

   assign word_index = req_tdata[4:0];
   assign word_value = req_tdata[36:5];
   assign nonce      = req_tdata[68:37];
   assign en         = !res_ff.valid || rsp_tready;
   assign req_tready = en;
   assign accept     = req_tvalid && en;
   assign tag1       = {hdr_ff[16], hdr_ff[17], hdr_ff[18], nonce};

   always_ff @(posedge clock) begin
      for (int i = 0; i < HeaderWords; i++) begin
         if (accept && !req_tuser && word_index == 5'(i)) begin
            hdr_ff[i] <= word_value;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         blk1[i] = hdr_ff[i];
      end
      blk2     = '0;
      blk2[0]  = d1.tag.w16;
      blk2[1]  = d1.tag.w17;
      blk2[2]  = d1.tag.w18;
      blk2[3]  = d1.tag.nonce;
      blk2[4]  = PAD_ONE;
      blk2[15] = LEN_HEADER;
      blk3     = '0;
      for (int i = 0; i < 8; i++) begin
         blk3[i] = d2.digest[i];
      end
      blk3[8]  = PAD_ONE;
      blk3[15] = LEN_DIGEST;
   end

   shad_comp u_comp1 (
      .clock, .reset, .en,
      .in_valid (accept && req_tuser),
      .in_h     (START_H),
      .in_blk   (blk1),
      .in_tag   (tag1),
      .out      (d1)
   );

   shad_comp u_comp2 (
      .clock, .reset, .en,
      .in_valid (d1.valid),
      .in_h     (d1.digest),
      .in_blk   (blk2),
      .in_tag   (d1.tag),
      .out      (d2)
   );

   shad_comp u_comp3 (
      .clock, .reset, .en,
      .in_valid (d2.valid),
      .in_h     (START_H),
      .in_blk   (blk3),
      .in_tag   (d2.tag),
      .out      (d3)
   );

   // digest as big-endian number, word 0 on top, then byte reversed
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         dig[255 - 32 * i -: 32] = d3.digest[i];
      end
      for (int i = 0; i < 32; i++) begin
         rev[255 - 8 * i -: 8] = dig[8 * i +: 8];
      end
      expo = d3.tag.w18[31:24];
      if (expo > 8'd32) begin
         shift = 5'd29;
      end else if (expo < 8'd3) begin
         shift = 5'd0;
      end else begin
         shift = 5'(expo - 8'd3);
      end
      target = {232'd0, d3.tag.w18[23:0]} << {shift, 3'b000};
      cmp_in.valid  = d3.valid;
      cmp_in.rev    = rev;
      cmp_in.target = target;
      cmp_in.nonce  = d3.tag.nonce;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_ff <= '0;
      end else if (en) begin
         cmp_ff <= cmp_in;
      end
   end

   // first nonzero nibble from the top wins
   always_comb begin
      res_in.valid = cmp_ff.valid;
      res_in.found = cmp_ff.rev < cmp_ff.target;
      res_in.nonce = cmp_ff.nonce;
      res_in.top   = cmp_ff.rev[255:192];
      res_in.zeros = 7'd64;
      for (int i = 63; i >= 0; i--) begin
         if (cmp_ff.rev[255 - 4 * i -: 4] != 4'd0) begin
            res_in.zeros = 7'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else if (en) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = res_ff.valid;
   assign rsp_tuser  = res_ff.found;
   assign rsp_tdata  = {1'b0, res_ff.top, res_ff.nonce, res_ff.zeros};

   a_zeros_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> res_ff.zeros <= 7'd64)
      else $error("zero digit count out of range");

   a_zeros_top : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && res_ff.top != 64'd0) |-> res_ff.zeros < 7'd16)
      else $error("zero digit count disagrees with hash top");

   a_top_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && res_ff.zeros >= 7'd16) |-> res_ff.top == 64'd0)
      else $error("hash top not zero for long zero run");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata) && $stable(cmp_ff))
      else $error("pipeline moved during stall");

endmodule

// ----- rtl/core/shad_comp.sv -----
// shad_comp: one sha-256 compression as a 64-stage round pipeline plus a final add stage
// depends on shad_pkg
module shad_comp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  shad_pkg::hash_type   in_h,
   input  shad_pkg::block_type  in_blk,
   input  shad_pkg::tag_type    in_tag,
   output shad_pkg::digest_type out
);
   import shad_pkg::*;

   stage_type  st_in;
   stage_type  st_ff [1:Rounds];
   digest_type out_ff;

   always_comb begin
      st_in.valid = in_valid;
      st_in.v     = in_h;
      st_in.h0    = in_h;
      st_in.w     = in_blk;
      st_in.tag   = in_tag;
   end

   for (genvar g = 1; g <= Rounds; g++) begin : g_round
      stage_type prev;
      if (g == 1) begin : g_first
         assign prev = st_in;
      end else begin : g_rest
         assign prev = st_ff[g - 1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[g] <= '0;
         end else if (en) begin
            st_ff[g] <= sha_round(prev, ROUND_K[g - 1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff <= '0;
      end else if (en) begin
         out_ff.valid <= st_ff[Rounds].valid;
         out_ff.tag   <= st_ff[Rounds].tag;
         for (int i = 0; i < 8; i++) begin
            out_ff.digest[i] <= st_ff[Rounds].v[i] + st_ff[Rounds].h0[i];
         end
      end
   end

   assign out = out_ff;

endmodule

// ----- tb/nonce_check_scoreboard.sv -----
// nonce_check_scoreboard: watches both beat channels of the header nonce checker, keeps its own
// header prefix copy, predicts the double sha-256 result of every try and compares it
// depends on nothing but the port layout of header_nonce_double_sha256_check_top
`timescale 1ns / 100ps

module nonce_check_scoreboard (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [71:0]  req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,
   input  logic         rsp_tuser,
   output int           fail_count,
   output int           pending,
   output int           hit_count
);

   typedef logic [7:0][31:0]  digest_t;
   typedef logic [15:0][31:0] msg_block_t;

   typedef struct {
      logic        found;
      logic [6:0]  zero_digits;
      logic [31:0] nonce;
      logic [63:0] hash_top;
   } verdict_t;

   localparam logic [0:63][31:0] K_TABLE = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [0:7][31:0] IV_TABLE = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] PAD_WORD = 32'h8000_0000;

   logic [31:0] prefix_words [19];
   verdict_t    expected_q [$];
   int          mismatch_total;
   int          hits;

   assign fail_count = mismatch_total;
   assign pending    = expected_q.size();
   assign hit_count  = hits;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      logic [63:0] twice;
      twice = {x, x} >> n;
      return twice[31:0];
   endfunction

   function automatic digest_t sha_compress(input digest_t hin, input msg_block_t blk);
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
      digest_t     hout;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++) begin
         s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      a = hin[0]; b = hin[1]; c = hin[2]; d = hin[3];
      e = hin[4]; f = hin[5]; g = hin[6]; hh = hin[7];
      for (int i = 0; i < 64; i++) begin
         t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
            + K_TABLE[i] + w[i];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         hh = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      hout[0] = hin[0] + a; hout[1] = hin[1] + b; hout[2] = hin[2] + c; hout[3] = hin[3] + d;
      hout[4] = hin[4] + e; hout[5] = hin[5] + f; hout[6] = hin[6] + g; hout[7] = hin[7] + hh;
      return hout;
   endfunction

   function automatic verdict_t predict_try(input logic [31:0] nonce);
      msg_block_t   blk;
      digest_t      iv, st;
      logic [255:0] rev_num, target;
      logic [7:0]   one_byte, expo;
      int           shift;
      verdict_t     v;
      for (int i = 0; i < 8; i++) iv[i] = IV_TABLE[i];
      for (int i = 0; i < 16; i++) blk[i] = prefix_words[i];
      st = sha_compress(iv, blk);
      blk = '0;
      blk[0] = prefix_words[16];
      blk[1] = prefix_words[17];
      blk[2] = prefix_words[18];
      blk[3] = nonce;
      blk[4] = PAD_WORD;
      blk[15] = 32'd640;
      st = sha_compress(st, blk);
      blk = '0;
      for (int i = 0; i < 8; i++) blk[i] = st[i];
      blk[8] = PAD_WORD;
      blk[15] = 32'd256;
      st = sha_compress(iv, blk);
      // byte j of the digest lands at byte 31-j of the reversed big-endian number
      for (int j = 0; j < 32; j++) begin
         one_byte = st[j / 4][31 - 8 * (j % 4) -: 8];
         rev_num[255 - 8 * (31 - j) -: 8] = one_byte;
      end
      expo = prefix_words[18][31:24];
      if (expo > 8'd32) expo = 8'd32;
      shift = (expo < 8'd3) ? 0 : int'(expo) - 3;
      target = 256'(prefix_words[18][23:0]) << (8 * shift);
      v.found = rev_num < target;
      v.zero_digits = 7'd64;
      for (int i = 0; i < 64; i++) begin
         if (rev_num[255 - 4 * i -: 4] != 4'h0) begin
            v.zero_digits = 7'(i);
            break;
         end
      end
      v.nonce = nonce;
      v.hash_top = rev_num[255:192];
      return v;
   endfunction

   always @(posedge clock) begin
      verdict_t    want;
      logic [4:0]  idx;
      logic        got_found;
      logic [6:0]  got_zd;
      logic [31:0] got_nonce;
      logic [63:0] got_top;
      if (reset) begin
         for (int i = 0; i < 19; i++) prefix_words[i] = '0;
         expected_q.delete();
         mismatch_total = 0;
         hits = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_found = rsp_tuser;
            got_zd    = rsp_tdata[6:0];
            got_nonce = rsp_tdata[38:7];
            got_top   = rsp_tdata[102:39];
            if (expected_q.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("%0t: unexpected result beat nonce=%h", $realtime, got_nonce);
            end else begin
               want = expected_q.pop_front();
               if (got_found !== want.found || got_zd !== want.zero_digits ||
                   got_nonce !== want.nonce || got_top !== want.hash_top) begin
                  mismatch_total++;
                  if (mismatch_total <= 10)
                     $display("%0t: mismatch exp found=%b zd=%0d nonce=%h top=%h %s",
                              $realtime, want.found, want.zero_digits, want.nonce,
                              want.hash_top,
                              $sformatf("/ got found=%b zd=%0d nonce=%h top=%h",
                                        got_found, got_zd, got_nonce, got_top));
               end
               if (want.found) hits++;
            end
         end
         if (req_tvalid && req_tready) begin
            idx = req_tdata[4:0];
            if (req_tuser) expected_q = {expected_q, predict_try(req_tdata[68:37])};
            else if (idx < 5'd19) prefix_words[idx] = req_tdata[36:5];
         end
      end
   end

endmodule

// ----- tb/tb_top.sv -----
// tb_top: drives header loads and nonce tries into header_nonce_double_sha256_check_top with
// random idling on both sides and gives the verdict; depends on nonce_check_scoreboard
`timescale 1ns / 100ps

module tb_top;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TRY  = 1'b1;
   localparam int   RANDOM_ITEMS = 1700;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [71:0]  req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;
   logic         rsp_tuser;
   int           fail_count;
   int           pending;
   int           hit_count;
   bit           no_idle;
   int           try_count;
   int           load_count;

   header_nonce_double_sha256_check_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   nonce_check_scoreboard checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .fail_count(fail_count), .pending(pending), .hit_count(hit_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("timeout");
      $display("RESULT: ERROR");
      $finish;
   end

   // receiver: random stall per beat, one long hold-off after a fixed number of beats
   initial begin
      int stall;
      int beats;
      bit held;
      stall = 0;
      beats = 0;
      held  = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_tvalid && rsp_tready) begin
            beats++;
            stall = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
         end
         if (!held && beats >= 700) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (600) @(posedge clock);
         end else begin
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               stall--;
            end else begin
               rsp_tready <= 1'b1;
            end
            @(posedge clock);
         end
      end
   end

   task automatic send_beat(input logic mode, input logic [4:0] idx,
                            input logic [31:0] value, input logic [31:0] nonce);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {3'b000, nonce, value, idx};
      do @(posedge clock); while (!req_tready);
      if (mode == MODE_TRY) try_count++;
      else if (idx < 5'd19) load_count++;
   endtask

   task automatic load_word(input logic [4:0] idx, input logic [31:0] value);
      send_beat(MODE_LOAD, idx, value, $urandom());
   endtask

   task automatic try_nonce(input logic [31:0] nonce);
      send_beat(MODE_TRY, 5'($urandom()), $urandom(), nonce);
   endtask

   function automatic logic [31:0] random_bits_word();
      logic [7:0] expo;
      case ($urandom_range(0, 5))
         0: expo = 8'($urandom_range(0, 2));
         1: expo = 8'($urandom_range(3, 32));
         2: expo = 8'($urandom_range(33, 255));
         default: expo = 8'($urandom_range(31, 32));
      endcase
      return {expo, 24'($urandom())};
   endfunction

   initial begin
      logic [4:0] idx;
      no_idle = 1'b0;
      try_count = 0;
      load_count = 0;
      reset = 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= MODE_LOAD;
      req_tdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: full header, field extremes, exponent corners, ignored indexes
      load_word(5'd0, 32'h0000_0000);
      load_word(5'd1, 32'hffff_ffff);
      for (int i = 2; i < 18; i++) load_word(5'(i), $urandom());
      load_word(5'd18, 32'h20ff_ffff);
      try_nonce(32'h0000_0000);
      try_nonce(32'hffff_ffff);
      load_word(5'd19, 32'hffff_ffff);
      load_word(5'd31, 32'h0000_0000);
      try_nonce(32'h1234_5678);
      load_word(5'd18, 32'h017f_ffff);
      try_nonce(32'h5555_5555);
      load_word(5'd18, 32'h0000_0000);
      try_nonce(32'haaaa_aaaa);
      load_word(5'd18, 32'h03ff_ffff);
      try_nonce(32'h0000_0001);
      load_word(5'd18, 32'hffff_ffff);
      try_nonce(32'h8000_0000);
      load_word(5'd18, 32'h1d00_ffff);
      try_nonce(32'h7fff_ffff);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         no_idle = (n >= 400 && n < 550);
         if (n == 1200) begin
            req_tvalid <= 1'b0;
            while (pending != 0) @(posedge clock);
         end
         case ($urandom_range(0, 19))
            0, 1: begin
               idx = 5'($urandom_range(0, 18));
               load_word(idx, (idx == 5'd18) ? random_bits_word() : $urandom());
            end
            2: load_word(5'd18, random_bits_word());
            3: begin
               load_word(5'($urandom_range(19, 31)), $urandom());
               n--;
            end
            default: try_nonce($urandom());
         endcase
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (250) @(posedge clock);
      $display("covered %0d nonce tries (%0d below target) and %0d header loads",
               try_count, hit_count, load_count);
      $display("with random gaps on both sides, a long output hold-off and a full drain");
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/shad_pkg.sv
rtl/core/shad_comp.sv
rtl/core/header_nonce_double_sha256_check_top.sv
tb/nonce_check_scoreboard.sv
tb/tb_top.sv
